>>> rtl/core/cdq_pkg.sv
package cdq_pkg;

  // Default sizing of the slot ring.
  localparam int DEPTH_DEF     = 8;
  localparam int WORD_BITS_DEF = 32;

  // Result word width and configuration port widths.
  localparam int OUT_W  = 32;
  localparam int CAP_W  = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;
  localparam logic [OUT_W-1:0] NEG_ONE   = '1;

  // Register index of the capacity register.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } cdq_req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_t;

  typedef struct packed {
    logic [OUT_W-1:0] data_out;
    cdq_status_t      status;
    logic             now_empty;
    logic             now_full;
    logic [OUT_W-1:0] head_value;
  } cdq_result_t;

endpackage

>>> rtl/core/circular_deque_core.sv
// A request's result is registered and offered in the cycle after it is accepted.
// Throughput: one request per cycle while results are taken; the queue state and the
// result register update together; the ring's two read ports prefetch neighbor words for pops.
// Reset (rst_n, synchronous, active low): queue empty, both pointers at slot 0,
// capacity 8, no result pending. Slot contents are not cleared.
module circular_deque_core #(
  parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic signed [31:0]                in_data_in,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_data_out,
  output logic [1:0]                        out_status,
  output logic                              out_now_empty,
  output logic                              out_now_full,
  output logic signed [31:0]                out_head_value,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cdq_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [cdq_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [cdq_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                              cfg_pready
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [cdq_pkg::CAP_W-1:0] cap;
  logic                      flush;
  logic                      accept;
  logic [WORD_BITS-1:0]      word;
  logic                      we;
  logic [PTR_W-1:0]          waddr;
  logic [PTR_W-1:0]          raddr_a;
  logic [PTR_W-1:0]          raddr_b;
  logic [WORD_BITS-1:0]      rdata_a;
  logic [WORD_BITS-1:0]      rdata_b;
  cdq_pkg::cdq_result_t      res;
  cdq_pkg::cdq_result_t      res_r;
  logic                      out_valid_r;

  // The result register frees up whenever its content is taken, so a new request
  // is accepted in the same cycle that the previous result leaves.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Words are held at WORD_BITS; the pushed word is the request's bit pattern,
  // zero-extended or truncated to that width.
  assign word = WORD_BITS'(unsigned'(in_data_in));

  cdq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cap         (cap),
    .flush       (flush)
  );

  cdq_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .PTR_W     (PTR_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .flush           (flush),
    .cap             (cap),
    .req             (cdq_pkg::cdq_req_t'(in_req_type)),
    .word            (word),
    .next_front_word (rdata_a),
    .prev_back_word  (rdata_b),
    .we              (we),
    .waddr           (waddr),
    .raddr_a         (raddr_a),
    .raddr_b         (raddr_b),
    .res             (res)
  );

  // The ring itself: one write port for pushes, two registered read ports that
  // track the slot after the front and the slot before the back.
  cdq_store #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .PTR_W     (PTR_W)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (word),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = signed'(res_r.data_out);
  assign out_status     = res_r.status;
  assign out_now_empty  = res_r.now_empty;
  assign out_now_full   = res_r.now_full;
  assign out_head_value = signed'(res_r.head_value);

endmodule

>>> rtl/core/cdq_cfg.sv
module cdq_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cdq_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [cdq_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [cdq_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output logic [cdq_pkg::CAP_W-1:0]    cap,
  output logic                         flush
);

  logic [cdq_pkg::CAP_W-1:0] cap_r;
  logic                      hit_cap;

  assign hit_cap    = (cfg_paddr[cdq_pkg::ADDR_W-1] == cdq_pkg::REG_CAPACITY);
  assign flush      = cfg_psel & cfg_penable & cfg_pwrite & hit_cap;
  assign cfg_pready = 1'b1;
  assign cap        = cap_r;

  always_comb begin
    cfg_prdata = '0;
    if (hit_cap) begin
      cfg_prdata = {{(cdq_pkg::DATA_W - cdq_pkg::CAP_W){1'b0}}, cap_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= cdq_pkg::CAP_RESET;
    end else if (flush) begin
      cap_r <= cfg_pwdata[cdq_pkg::CAP_W-1:0];
    end
  end

endmodule

>>> rtl/core/cdq_store.sv
module cdq_store #(
  parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF,
  parameter int PTR_W     = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [PTR_W-1:0]     waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [PTR_W-1:0]     raddr_a,
  input  logic [PTR_W-1:0]     raddr_b,
  output logic [WORD_BITS-1:0] rdata_a,
  output logic [WORD_BITS-1:0] rdata_b
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_a_r;
  logic [WORD_BITS-1:0] rdata_b_r;

  // Write-first: a read of the slot being written returns the new word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr_a)) begin
      rdata_a_r <= wdata;
    end else begin
      rdata_a_r <= mem[raddr_a];
    end
    if (we && (waddr == raddr_b)) begin
      rdata_b_r <= wdata;
    end else begin
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> rtl/core/cdq_ctrl.sv
module cdq_ctrl #(
  parameter int DEPTH     = cdq_pkg::DEPTH_DEF,
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEF,
  parameter int PTR_W     = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       flush,
  input  logic [cdq_pkg::CAP_W-1:0]  cap,
  input  cdq_pkg::cdq_req_t          req,
  input  logic [WORD_BITS-1:0]       word,
  input  logic [WORD_BITS-1:0]       next_front_word,
  input  logic [WORD_BITS-1:0]       prev_back_word,
  output logic                       we,
  output logic [PTR_W-1:0]           waddr,
  output logic [PTR_W-1:0]           raddr_a,
  output logic [PTR_W-1:0]           raddr_b,
  output cdq_pkg::cdq_result_t       res
);

  logic [PTR_W-1:0]     front_r, front_nxt;
  logic [PTR_W-1:0]     back_r, back_nxt;
  logic                 empty_r, empty_nxt;
  logic [WORD_BITS-1:0] head_r, head_nxt;
  logic [WORD_BITS-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0]     last;
  logic                 full_cur;
  logic [cdq_pkg::OUT_W-1:0] dout;
  cdq_pkg::cdq_status_t status;

  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] i,
                                               input logic [PTR_W-1:0] lst);
    step_up = (i == lst) ? '0 : i + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] i,
                                                 input logic [PTR_W-1:0] lst);
    step_down = (i == '0) ? lst : i - PTR_W'(1);
  endfunction

  function automatic logic [cdq_pkg::OUT_W-1:0] to_out(input logic [WORD_BITS-1:0] w);
    to_out = cdq_pkg::OUT_W'(signed'(w));
  endfunction

  // Highest slot index in use; zero acts as one slot, large values clamp to the ring.
  always_comb begin
    if (cap == '0) begin
      last = '0;
    end else if (32'(cap) > DEPTH) begin
      last = PTR_W'(DEPTH - 1);
    end else begin
      last = PTR_W'(cap - cdq_pkg::CAP_W'(1));
    end
  end

  assign full_cur = !empty_r && (step_up(back_r, last) == front_r);

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    empty_nxt = empty_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    we        = 1'b0;
    waddr     = '0;
    dout      = '0;
    status    = cdq_pkg::ST_DONE;
    if (flush) begin
      front_nxt = '0;
      back_nxt  = '0;
      empty_nxt = 1'b1;
    end else if (accept) begin
      case (req)
        cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_BACK: begin
          if (full_cur) begin
            status = cdq_pkg::ST_FULL;
          end else if (empty_r) begin
            front_nxt = '0;
            back_nxt  = '0;
            empty_nxt = 1'b0;
            we        = 1'b1;
            waddr     = '0;
            head_nxt  = word;
            tail_nxt  = word;
          end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
            front_nxt = step_down(front_r, last);
            we        = 1'b1;
            waddr     = front_nxt;
            head_nxt  = word;
          end else begin
            back_nxt = step_up(back_r, last);
            we       = 1'b1;
            waddr    = back_nxt;
            tail_nxt = word;
          end
        end
        cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_BACK: begin
          if (empty_r) begin
            status = cdq_pkg::ST_EMPTY;
            dout   = cdq_pkg::NEG_ONE;
          end else begin
            dout = (req == cdq_pkg::REQ_POP_FRONT) ? to_out(head_r) : to_out(tail_r);
            if (front_r == back_r) begin
              front_nxt = '0;
              back_nxt  = '0;
              empty_nxt = 1'b1;
            end else if (req == cdq_pkg::REQ_POP_FRONT) begin
              front_nxt = step_up(front_r, last);
              head_nxt  = next_front_word;
            end else begin
              back_nxt = step_down(back_r, last);
              tail_nxt = prev_back_word;
            end
          end
        end
        default: begin
          status = cdq_pkg::ST_DONE;
        end
      endcase
    end
  end

  // Prefetch the words that would become the front or back after a pop.
  assign raddr_a = step_up(front_nxt, last);
  assign raddr_b = step_down(back_nxt, last);

  always_comb begin
    res.data_out   = dout;
    res.status     = status;
    res.now_empty  = empty_nxt;
    res.now_full   = !empty_nxt && (step_up(back_nxt, last) == front_nxt);
    res.head_value = empty_nxt ? cdq_pkg::NEG_ONE : to_out(head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

>>> verif/circular_deque_core_test.sv
`timescale 1ns / 1ps

module circular_deque_core_test;

  // Cycles without any accepted request, result or register write before the
  // run is declared hung. The longest legal quiet stretch is the receiver hold
  // below, so this leaves a wide margin.
  localparam int STALL_LIMIT = 1000;
  // Length of the deliberate receiver hold in the backpressure test.
  localparam int HOLD_CYCLES = 80;
  // Byte address of the capacity register on the configuration port.
  localparam logic [cdq_pkg::ADDR_W-1:0] CAP_ADDR =
    cdq_pkg::ADDR_W'(4 * cdq_pkg::REG_CAPACITY);
  // Slots in the ring of predicted results; far more than can be outstanding.
  localparam int DUE_SLOTS = 16;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [1:0]                  in_req_type;
  logic signed [31:0]          in_data_in;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [31:0]          out_data_out;
  logic [1:0]                  out_status;
  logic                        out_now_empty;
  logic                        out_now_full;
  logic signed [31:0]          out_head_value;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [cdq_pkg::ADDR_W-1:0]  cfg_paddr;
  logic [cdq_pkg::DATA_W-1:0]  cfg_pwdata;
  logic [cdq_pkg::DATA_W-1:0]  cfg_prdata;
  logic                        cfg_pready;

  circular_deque_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_now_empty  (out_now_empty),
    .out_now_full   (out_now_full),
    .out_head_value (out_head_value),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // Shadow copy of the deque. The slot ring, both pointers, the empty mark and
  // the raw capacity register are tracked exactly as the block keeps them.
  logic [cdq_pkg::OUT_W-1:0] ring [cdq_pkg::DEPTH_DEF];
  int                        front_at;
  int                        back_at;
  bit                        ring_empty;
  logic [cdq_pkg::CAP_W-1:0] cap_reg;

  // Results predicted for accepted requests, oldest first. The write and read
  // counts only grow; their difference is the number outstanding.
  cdq_pkg::cdq_result_t due_ring [DUE_SLOTS];
  int                   due_wr;
  int                   due_rd;

  int  failures;
  int  quiet_cycles;
  // When set, neither side inserts random idle cycles; a requested receiver hold still applies.
  bit  steady;
  // Raised by a test to make the receiver hold off; the receiver clears it when the hold ends.
  bit  hold_results;
  int  tx_calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A capacity of zero behaves as one, anything above the ring size as the
  // full ring.
  function automatic int live_cap();
    if (cap_reg == '0) return 1;
    if (cap_reg > cdq_pkg::DEPTH_DEF) return cdq_pkg::DEPTH_DEF;
    return int'(cap_reg);
  endfunction

  function automatic int step_up(int i);
    return (i + 1 >= live_cap()) ? 0 : i + 1;
  endfunction

  function automatic int step_down(int i);
    return (i == 0 || i >= live_cap()) ? live_cap() - 1 : i - 1;
  endfunction

  function automatic void flush_ring();
    front_at   = 0;
    back_at    = 0;
    ring_empty = 1'b1;
  endfunction

  // Full means the slot after the back pointer, wrapping at the capacity in
  // use, is the front pointer.
  function automatic bit ring_full();
    return !ring_empty && step_up(back_at) == front_at;
  endfunction

  // Applies one request to the shadow deque and returns the result it causes.
  function automatic cdq_pkg::cdq_result_t apply_request(cdq_pkg::cdq_req_t req,
                                                         logic [cdq_pkg::OUT_W-1:0] word);
    cdq_pkg::cdq_result_t r;
    r.data_out = '0;
    r.status   = cdq_pkg::ST_DONE;
    if (req == cdq_pkg::REQ_PUSH_FRONT || req == cdq_pkg::REQ_PUSH_BACK) begin
      if (ring_full()) begin
        r.status = cdq_pkg::ST_FULL;
      end else if (ring_empty) begin
        // The first entry always lands in slot 0, whichever end it is pushed at.
        front_at   = 0;
        back_at    = 0;
        ring_empty = 1'b0;
        ring[0]    = word;
      end else if (req == cdq_pkg::REQ_PUSH_FRONT) begin
        front_at       = step_down(front_at);
        ring[front_at] = word;
      end else begin
        back_at       = step_up(back_at);
        ring[back_at] = word;
      end
    end else begin
      if (ring_empty) begin
        r.status   = cdq_pkg::ST_EMPTY;
        r.data_out = cdq_pkg::NEG_ONE;
      end else begin
        r.data_out = (req == cdq_pkg::REQ_POP_FRONT) ? ring[front_at] : ring[back_at];
        // Removing the only entry returns both pointers to slot 0.
        if (front_at == back_at) flush_ring();
        else if (req == cdq_pkg::REQ_POP_FRONT) front_at = step_up(front_at);
        else back_at = step_down(back_at);
      end
    end
    r.now_empty  = ring_empty;
    r.now_full   = ring_full();
    r.head_value = ring_empty ? cdq_pkg::NEG_ONE : ring[front_at];
    return r;
  endfunction

  task automatic note_failure(string what);
    failures++;
    if (failures <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Offers one request. Valid is left high on return so that back-to-back
  // requests keep it asserted; wait_idle lowers it.
  task automatic send_request(cdq_pkg::cdq_req_t req, logic [cdq_pkg::OUT_W-1:0] word);
    cdq_pkg::cdq_result_t r;
    @(negedge clk);
    if (!steady) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else if ($urandom_range(0, 99) < 12) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else if ($urandom_range(0, 99) < 4) begin
        tx_calm = $urandom_range(20, 60);
      end
    end
    in_valid    = 1'b1;
    in_req_type = req;
    in_data_in  = word;
    do @(posedge clk); while (!in_ready);
    r = apply_request(req, word);
    due_ring[due_wr % DUE_SLOTS] = r;
    due_wr++;
  endtask

  // Picks a push with the given percentage, otherwise a pop, at a random end.
  // Words lean toward the extremes of the signed range.
  task automatic send_mixed(int push_pct);
    cdq_pkg::cdq_req_t         req;
    logic [cdq_pkg::OUT_W-1:0] word;
    bit                        at_front;
    at_front = $urandom_range(0, 1);
    if ($urandom_range(1, 100) <= push_pct) begin
      req = at_front ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_BACK;
    end else begin
      req = at_front ? cdq_pkg::REQ_POP_FRONT : cdq_pkg::REQ_POP_BACK;
    end
    case ($urandom_range(0, 9))
      0:       word = 32'h8000_0000;
      1:       word = 32'h7FFF_FFFF;
      2:       word = '0;
      3:       word = '1;
      default: word = $urandom();
    endcase
    send_request(req, word);
  endtask

  // Stops offering requests and waits until every predicted result is back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_wr != due_rd) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where the access phase meets pready. Any write flushes the deque.
  task automatic write_capacity(logic [cdq_pkg::DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CAP_ADDR;
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cap_reg = value[cdq_pkg::CAP_W-1:0];
    flush_ring();
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Pops on the empty deque, a fill at alternating ends with the extreme
  // words, pushes rejected as full, then pops down past the last entry.
  task automatic test_after_reset();
    logic [cdq_pkg::OUT_W-1:0] words [8];
    words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
              32'h1, 32'h2, 32'h3, 32'h4};
    send_request(cdq_pkg::REQ_POP_FRONT, 32'h5555_5555);
    send_request(cdq_pkg::REQ_POP_BACK, 32'hAAAA_AAAA);
    for (int i = 0; i < 8; i++) begin
      send_request((i % 2) ? cdq_pkg::REQ_PUSH_BACK : cdq_pkg::REQ_PUSH_FRONT, words[i]);
    end
    send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h5);
    send_request(cdq_pkg::REQ_PUSH_BACK, 32'h6);
    for (int i = 0; i < 8; i++) begin
      send_request((i % 2) ? cdq_pkg::REQ_POP_BACK : cdq_pkg::REQ_POP_FRONT, '0);
    end
    send_request(cdq_pkg::REQ_POP_BACK, '0);
    wait_idle();
  endtask

  // A one-slot deque is full after its first push and empty after one pop.
  task automatic test_single_slot();
    write_capacity(32'd1);
    send_request(cdq_pkg::REQ_PUSH_BACK, 32'h1234_5678);
    send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h8765_4321);
    send_request(cdq_pkg::REQ_POP_FRONT, '0);
    send_request(cdq_pkg::REQ_POP_BACK, '0);
    wait_idle();
  endtask

  // The receiver stops taking results for a long stretch while requests keep
  // coming, so the result register stays occupied and the input stalls.
  task automatic test_backpressure();
    write_capacity(32'd8);
    steady       = 1'b1;
    hold_results = 1'b1;
    repeat (30) send_mixed(70);
    wait_idle();
    steady = 1'b0;
  endtask

  // Phases over many capacities, including zero and values above the ring
  // size. Within a phase the traffic swings between filling and draining so
  // that both the full and the empty boundaries are hit repeatedly. The last
  // phase runs with no idling on either side.
  task automatic test_random_traffic();
    logic [cdq_pkg::CAP_W-1:0] caps [12];
    bit                        filling;
    int                        count;
    caps = '{4'd8, 4'd1, 4'd2, 4'd15, 4'd0, 4'd3, 4'd9, 4'd5, 4'd7, 4'd4, 4'd6, 4'd8};
    for (int p = 0; p < 12; p++) begin
      write_capacity(($urandom() & 32'hFFFF_FFF0) | cdq_pkg::DATA_W'(caps[p]));
      filling = 1'b1;
      count   = 95;
      if (p == 11) begin
        steady = 1'b1;
        count  = 180;
      end
      for (int n = 0; n < count; n++) begin
        if (filling && ring_full()) filling = 1'b0;
        else if (!filling && ring_empty) filling = 1'b1;
        if ($urandom_range(0, 9) == 0) send_mixed(50);
        else send_mixed(filling ? 80 : 20);
      end
      wait_idle();
    end
  endtask

  // Receiver: random stall bursts, calm stretches, and the long hold on request.
  initial begin : result_sink
    int calm;
    calm      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_results = 1'b0;
      end else if (!steady && calm == 0 && $urandom_range(0, 99) < 10) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 99) < 3) calm = $urandom_range(20, 60);
      end
    end
  end

  // Every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    cdq_pkg::cdq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_wr == due_rd) begin
        note_failure("result with no request outstanding");
      end else begin
        want = due_ring[due_rd % DUE_SLOTS];
        due_rd++;
        if (out_data_out !== want.data_out || out_status !== want.status ||
            out_now_empty !== want.now_empty || out_now_full !== want.now_full ||
            out_head_value !== want.head_value) begin
          note_failure($sformatf(
            "expected data %h status %0d empty %0b full %0b head %h, got %h %0d %0b %0b %h",
            want.data_out, want.status, want.now_empty, want.now_full, want.head_value,
            out_data_out, out_status, out_now_empty, out_now_full, out_head_value));
        end
      end
    end
  end

  // Hang detector: counts cycles in which nothing at all is accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = cdq_pkg::REQ_PUSH_FRONT;
    in_data_in   = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    failures     = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    hold_results = 1'b0;
    tx_calm      = 0;
    due_wr       = 0;
    due_rd       = 0;
    foreach (ring[i]) ring[i] = '0;
    cap_reg = cdq_pkg::CAP_RESET;
    flush_ring();

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_single_slot();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (4) @(posedge clk);
    if (failures == 0 && due_wr == due_rd) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
